// File: hdl/necir_pkg.sv
package necir_pkg;

   // field widths
   localparam int TICK_W = 15;
   localparam int DIV_W  = 8;
   localparam int US_W   = 20;
   localparam int IDX_W  = 6;
   localparam int BYTE_W = 8;

   // divider retires two quotient bits per step
   localparam int DIV_STEPS = US_W / 2;
   localparam int STEP_W    = $clog2(DIV_STEPS + 1);

   localparam logic [DIV_W-1:0] TICKS_RESET = DIV_W'(8);

   // pulse timing in microseconds
   localparam logic [US_W-1:0] LEADER_MARK_US  = US_W'(9000);
   localparam logic [US_W-1:0] LEADER_SPACE_US = US_W'(4500);
   localparam logic [US_W-1:0] LEADER_TOL_US   = US_W'(200);
   localparam logic [US_W-1:0] BIT_MARK_US     = US_W'(560);
   localparam logic [US_W-1:0] ZERO_SPACE_US   = US_W'(560);
   localparam logic [US_W-1:0] ONE_SPACE_US    = US_W'(1690);
   localparam logic [US_W-1:0] BIT_TOL_US      = US_W'(100);

   // byte boundaries within the frame
   localparam logic [IDX_W-1:0] IDX_ADDR     = IDX_W'(8);
   localparam logic [IDX_W-1:0] IDX_ADDR_INV = IDX_W'(16);
   localparam logic [IDX_W-1:0] IDX_CMD      = IDX_W'(24);
   localparam logic [IDX_W-1:0] IDX_CMD_INV  = IDX_W'(32);
   localparam logic [IDX_W-1:0] IDX_MAX      = IDX_W'(63);

   // result status codes
   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_BAD_LEADER = 2'd1;
   localparam logic [1:0] STATUS_MISMATCH   = 2'd2;

   typedef struct packed {
      logic [TICK_W-1:0] low_ticks;
      logic [TICK_W-1:0] high_ticks;
      logic              last_item;
   } req_type;

   typedef struct packed {
      logic              frame_valid;
      logic [1:0]        status;
      logic [BYTE_W-1:0] address;
      logic [BYTE_W-1:0] command;
   } rsp_type;

   // one converted pulse pair handed to the frame tracker
   typedef struct packed {
      logic            update;
      logic            last_item;
      logic [US_W-1:0] mark_us;
      logic [US_W-1:0] space_us;
   } pair_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MARK,
      ST_SPACE,
      ST_UPDATE
   } seq_state_type;

endpackage

// File: hdl/necir_div.sv
module necir_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [necir_pkg::US_W-1:0]         dividend,
   input  logic [necir_pkg::DIV_W-1:0]        divisor,
   output logic                               done,
   output logic [necir_pkg::US_W-1:0]         quotient
);

   localparam int US_W   = necir_pkg::US_W;
   localparam int DIV_W  = necir_pkg::DIV_W;
   localparam int STEP_W = necir_pkg::STEP_W;

   logic [DIV_W-1:0]  den_ff, den_in;
   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [US_W-1:0]   quo_ff, quo_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              done_ff, done_in;

   logic [DIV_W:0]    den_ext;
   logic [DIV_W:0]    part1, part2, sub1, sub2;
   logic              ge1, ge2;
   logic [DIV_W-1:0]  rem1;

   // two restoring steps per cycle
   always_comb begin
      den_ext = {1'b0, den_ff};
      part1   = {rem_ff, quo_ff[US_W-1]};
      ge1     = (part1 >= den_ext);
      sub1    = ge1 ? (part1 - den_ext) : part1;
      rem1    = sub1[DIV_W-1:0];
      part2   = {rem1, quo_ff[US_W-2]};
      ge2     = (part2 >= den_ext);
      sub2    = ge2 ? (part2 - den_ext) : part2;
   end

   // operand load and step control
   always_comb begin
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         den_in = (divisor == '0) ? DIV_W'(1) : divisor;
         rem_in = '0;
         quo_in = dividend;
         cnt_in = STEP_W'(necir_pkg::DIV_STEPS);
      end else if (cnt_ff != '0) begin
         rem_in  = sub2[DIV_W-1:0];
         quo_in  = {quo_ff[US_W-3:0], ge1, ge2};
         cnt_in  = cnt_ff - STEP_W'(1);
         done_in = (cnt_ff == STEP_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: hdl/necir_frame.sv
module necir_frame (
   input  logic                clock,
   input  logic                reset,
   input  necir_pkg::pair_type pair,
   output necir_pkg::rsp_type  result
);

   localparam int US_W   = necir_pkg::US_W;
   localparam int IDX_W  = necir_pkg::IDX_W;
   localparam int BYTE_W = necir_pkg::BYTE_W;

   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              leader_ff, leader_in;
   logic [2:0]        bits_ff, bits_in;
   logic [BYTE_W-1:0] shift_ff, shift_in;
   logic [BYTE_W-1:0] addr_ff, addr_in;
   logic [BYTE_W-1:0] addr_inv_ff, addr_inv_in;
   logic [BYTE_W-1:0] cmd_ff, cmd_in;
   logic [BYTE_W-1:0] cmd_inv_ff, cmd_inv_in;

   logic is_leader, is_zero, is_one;

   function automatic logic in_window(input logic [US_W-1:0] us,
                                      input logic [US_W-1:0] ref_us,
                                      input logic [US_W-1:0] tol_us);
      in_window = (us >= ref_us - tol_us) && (us <= ref_us + tol_us);
   endfunction

   // pair classification, a zero space always passes the space check
   always_comb begin
      is_leader = in_window(pair.mark_us, necir_pkg::LEADER_MARK_US,
                            necir_pkg::LEADER_TOL_US)
               && (pair.space_us == '0
                   || in_window(pair.space_us, necir_pkg::LEADER_SPACE_US,
                                necir_pkg::LEADER_TOL_US));
      is_zero   = in_window(pair.mark_us, necir_pkg::BIT_MARK_US, necir_pkg::BIT_TOL_US)
               && (pair.space_us == '0
                   || in_window(pair.space_us, necir_pkg::ZERO_SPACE_US,
                                necir_pkg::BIT_TOL_US));
      is_one    = in_window(pair.mark_us, necir_pkg::BIT_MARK_US, necir_pkg::BIT_TOL_US)
               && (pair.space_us == '0
                   || in_window(pair.space_us, necir_pkg::ONE_SPACE_US,
                                necir_pkg::BIT_TOL_US));
   end

   // next frame state for this pair
   always_comb begin
      leader_in   = leader_ff;
      bits_in     = bits_ff;
      shift_in    = shift_ff;
      addr_in     = addr_ff;
      addr_inv_in = addr_inv_ff;
      cmd_in      = cmd_ff;
      cmd_inv_in  = cmd_inv_ff;
      if (idx_ff == '0) begin
         leader_in = is_leader;
      end else if (leader_ff) begin
         if (is_zero) begin
            shift_in = {1'b0, shift_ff[BYTE_W-1:1]};
         end else if (is_one) begin
            shift_in = {1'b1, shift_ff[BYTE_W-1:1]};
         end
         if (bits_ff == 3'd7) begin
            bits_in = '0;
            if (idx_ff == necir_pkg::IDX_ADDR) begin
               addr_in = shift_in;
            end else if (idx_ff == necir_pkg::IDX_ADDR_INV) begin
               addr_inv_in = shift_in;
            end else if (idx_ff == necir_pkg::IDX_CMD) begin
               cmd_in = shift_in;
            end else if (idx_ff == necir_pkg::IDX_CMD_INV) begin
               cmd_inv_in = shift_in;
            end
            shift_in = '0;
         end else begin
            bits_in = bits_ff + 3'd1;
         end
      end
      idx_in = (idx_ff < necir_pkg::IDX_MAX) ? idx_ff + IDX_W'(1) : idx_ff;
   end

   // frame verdict from the updated bytes
   always_comb begin
      result = '0;
      if (!leader_in) begin
         result.status = necir_pkg::STATUS_BAD_LEADER;
      end else if (addr_in != ~addr_inv_in || cmd_in != ~cmd_inv_in) begin
         result.status = necir_pkg::STATUS_MISMATCH;
      end else begin
         result.frame_valid = 1'b1;
         result.status      = necir_pkg::STATUS_OK;
         result.address     = addr_in;
         result.command     = cmd_in;
      end
   end

   // frame state, cleared after the last pair
   always_ff @(posedge clock) begin
      if (reset || (pair.update && pair.last_item)) begin
         idx_ff      <= '0;
         leader_ff   <= 1'b0;
         bits_ff     <= '0;
         shift_ff    <= '0;
         addr_ff     <= '0;
         addr_inv_ff <= '0;
         cmd_ff      <= '0;
         cmd_inv_ff  <= '0;
      end else if (pair.update) begin
         idx_ff      <= idx_in;
         leader_ff   <= leader_in;
         bits_ff     <= bits_in;
         shift_ff    <= shift_in;
         addr_ff     <= addr_in;
         addr_inv_ff <= addr_inv_in;
         cmd_ff      <= cmd_in;
         cmd_inv_ff  <= cmd_inv_in;
      end
   end

endmodule

// File: hdl/nec_ir_frame_decoder_core.sv
// channel   direction  handshake          beat
// req_      in         valid / stall      req_type: low_ticks, high_ticks, last_item
// rsp_      out        valid / stall      rsp_type: frame_valid, status, address, command
// csr_      in         valid / ready      ticks_per_ten_us, 8 bits
//
// one pulse pair holds req_stall high from accept until its update:
// two 10-step radix-4 divisions on the shared divider plus load and update.
// a result, on the last pair only, sits in rsp_data until taken; the next pair
// is accepted meanwhile, and a pair that ends the next frame waits at its
// update while that result is still held.
// synchronous reset returns the divisor to 8 and clears all frame state.
module nec_ir_frame_decoder_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  necir_pkg::req_type                 req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output necir_pkg::rsp_type                 rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [necir_pkg::DIV_W-1:0]        csr_data
);

   localparam int US_W   = necir_pkg::US_W;
   localparam int TICK_W = necir_pkg::TICK_W;

   necir_pkg::seq_state_type state_ff, state_in;
   necir_pkg::req_type       req_ff;
   necir_pkg::rsp_type       rsp_ff;
   necir_pkg::rsp_type       result;
   necir_pkg::pair_type      pair;

   logic [necir_pkg::DIV_W-1:0] ticks_ff;
   logic [US_W-1:0]             mark_us_ff;
   logic                        rsp_valid_ff, rsp_valid_in;

   logic                        div_start;
   logic [TICK_W-1:0]           div_ticks;
   logic [US_W-1:0]             div_dividend;
   logic                        div_done;
   logic [US_W-1:0]             div_quotient;
   logic                        accept, rsp_free;

   assign accept   = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // ticks times ten, widened for the divider
   assign div_dividend = US_W'({div_ticks, 3'b000}) + US_W'({div_ticks, 1'b0});

   necir_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (ticks_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   necir_frame u_frame (
      .clock  (clock),
      .reset  (reset),
      .pair   (pair),
      .result (result)
   );

   // sequencer
   always_comb begin
      state_in        = state_ff;
      req_stall       = (state_ff != necir_pkg::ST_IDLE);
      div_start       = 1'b0;
      div_ticks       = req_data.low_ticks;
      pair.update     = 1'b0;
      pair.last_item  = req_ff.last_item;
      pair.mark_us    = mark_us_ff;
      pair.space_us   = div_quotient;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         necir_pkg::ST_IDLE: begin
            if (req_valid) begin
               div_start = 1'b1;
               state_in  = necir_pkg::ST_MARK;
            end
         end
         necir_pkg::ST_MARK: begin
            div_ticks = req_ff.high_ticks;
            if (div_done) begin
               div_start = 1'b1;
               state_in  = necir_pkg::ST_SPACE;
            end
         end
         necir_pkg::ST_SPACE: begin
            if (div_done) begin
               state_in = necir_pkg::ST_UPDATE;
            end
         end
         necir_pkg::ST_UPDATE: begin
            if (!req_ff.last_item || rsp_free) begin
               pair.update = 1'b1;
               state_in    = necir_pkg::ST_IDLE;
               if (req_ff.last_item) begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         default: begin
            state_in = necir_pkg::ST_IDLE;
         end
      endcase
   end

   // space quotient is held in the divider until the update
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= necir_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         ticks_ff     <= necir_pkg::TICKS_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            ticks_ff <= csr_data;
         end
      end
      if (accept) begin
         req_ff <= req_data;
      end
      if (state_ff == necir_pkg::ST_MARK && div_done) begin
         mark_us_ff <= div_quotient;
      end
      if (pair.update && req_ff.last_item) begin
         rsp_ff <= result;
      end
   end

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: tb/sv/tb_nec_ir_frame_decoder_core.sv
`timescale 1ns / 1ps

module tb_nec_ir_frame_decoder_core;

   localparam int TICK_W = necir_pkg::TICK_W;
   localparam int DIV_W  = necir_pkg::DIV_W;
   localparam int IDX_W  = necir_pkg::IDX_W;

   localparam int QUIET_LIMIT  = 3000;
   localparam int SETTLE_TICKS = 40;
   localparam int PHASE_BEATS  = 145;

   // one directed beat, with a typed-in result where it is obvious
   typedef struct packed {
      logic [TICK_W-1:0]  mark;
      logic [TICK_W-1:0]  space;
      logic               last;
      logic               fixed;
      necir_pkg::rsp_type want;
   } dir_row_type;

   localparam necir_pkg::rsp_type RSP_NONE       = '0;
   localparam necir_pkg::rsp_type RSP_BAD_LEADER =
      '{1'b0, necir_pkg::STATUS_BAD_LEADER, 8'h00, 8'h00};
   localparam necir_pkg::rsp_type RSP_MISMATCH   =
      '{1'b0, necir_pkg::STATUS_MISMATCH, 8'h00, 8'h00};

   // ticks at the reset divisor of 8: leader 7200/3600, bit mark 448,
   // zero space 448, one space 1352
   localparam dir_row_type DIR_ROWS [15] = '{
      '{15'd0,     15'd0,     1'b1, 1'b1, RSP_BAD_LEADER},
      '{15'h7fff,  15'h7fff,  1'b1, 1'b1, RSP_BAD_LEADER},
      '{15'd7200,  15'd3600,  1'b1, 1'b1, RSP_MISMATCH},
      '{15'd7200,  15'd0,     1'b0, 1'b0, RSP_NONE},
      '{15'd448,   15'd1352,  1'b0, 1'b0, RSP_NONE},
      '{15'd448,   15'd448,   1'b0, 1'b0, RSP_NONE},
      '{15'd448,   15'd0,     1'b0, 1'b0, RSP_NONE},
      '{15'd100,   15'd100,   1'b0, 1'b0, RSP_NONE},
      '{15'd448,   15'd1352,  1'b1, 1'b0, RSP_NONE},
      '{15'd7360,  15'd3440,  1'b0, 1'b0, RSP_NONE},
      '{15'd528,   15'd1432,  1'b1, 1'b0, RSP_NONE},
      '{15'd7361,  15'd3600,  1'b0, 1'b0, RSP_NONE},
      '{15'd448,   15'd448,   1'b1, 1'b1, RSP_BAD_LEADER},
      '{15'h7fff,  15'd0,     1'b0, 1'b0, RSP_NONE},
      '{15'd0,     15'h7fff,  1'b1, 1'b1, RSP_BAD_LEADER}
   };

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   necir_pkg::req_type req_data = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   necir_pkg::rsp_type rsp_data;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [DIV_W-1:0]   csr_data = '0;

   // typed-in result travelling alongside the request beat
   logic               req_fixed = 1'b0;
   necir_pkg::rsp_type req_fixed_rsp = '0;

   // decoder mirror: divisor and frame state
   logic [DIV_W-1:0]  tick_div = necir_pkg::TICKS_RESET;
   logic [IDX_W-1:0]  frame_pos = '0;
   logic              leader_seen = 1'b0;
   logic [2:0]        bits_in_byte = '0;
   logic [7:0]        byte_acc = '0;
   logic [7:0]        addr_b = '0;
   logic [7:0]        addr_inv_b = '0;
   logic [7:0]        cmd_b = '0;
   logic [7:0]        cmd_inv_b = '0;

   necir_pkg::rsp_type pending_frames [$];
   int                 fail_count = 0;
   int                 beats_sent = 0;
   int                 burst_left = 0;
   int                 quiet_cycles = 0;
   int                 stall_left = 0;
   int                 stall_pct = 0;

   nec_ir_frame_decoder_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ticks to microseconds, a zero divisor acts as one
   function automatic int ticks_to_us(input logic [TICK_W-1:0] ticks);
      int d;
      d = (tick_div == 0) ? 1 : int'(tick_div);
      return (int'(ticks) * 10) / d;
   endfunction

   function automatic bit pair_fits(input int mark_us, input int space_us,
                                    input int mark_ref, input int space_ref,
                                    input int tol);
      if (mark_us < mark_ref - tol || mark_us > mark_ref + tol)
         return 1'b0;
      if (space_us != 0 && (space_us < space_ref - tol || space_us > space_ref + tol))
         return 1'b0;
      return 1'b1;
   endfunction

   // advance the frame mirror by one pulse pair, report a result on the last pair
   function automatic bit decode_pair(input necir_pkg::req_type p,
                                      output necir_pkg::rsp_type r);
      int mark_us;
      int space_us;
      mark_us  = ticks_to_us(p.low_ticks);
      space_us = ticks_to_us(p.high_ticks);
      r = '0;
      if (frame_pos == 0) begin
         leader_seen = pair_fits(mark_us, space_us, int'(necir_pkg::LEADER_MARK_US),
                                 int'(necir_pkg::LEADER_SPACE_US),
                                 int'(necir_pkg::LEADER_TOL_US));
      end else if (leader_seen) begin
         if (pair_fits(mark_us, space_us, int'(necir_pkg::BIT_MARK_US),
                       int'(necir_pkg::ZERO_SPACE_US), int'(necir_pkg::BIT_TOL_US)))
            byte_acc = byte_acc >> 1;
         else if (pair_fits(mark_us, space_us, int'(necir_pkg::BIT_MARK_US),
                            int'(necir_pkg::ONE_SPACE_US), int'(necir_pkg::BIT_TOL_US)))
            byte_acc = (byte_acc >> 1) | 8'h80;
         if (bits_in_byte == 3'd7) begin
            bits_in_byte = '0;
            case (frame_pos)
               necir_pkg::IDX_ADDR:     addr_b = byte_acc;
               necir_pkg::IDX_ADDR_INV: addr_inv_b = byte_acc;
               necir_pkg::IDX_CMD:      cmd_b = byte_acc;
               necir_pkg::IDX_CMD_INV:  cmd_inv_b = byte_acc;
               default: ;
            endcase
            byte_acc = '0;
         end else begin
            bits_in_byte = bits_in_byte + 3'd1;
         end
      end
      if (frame_pos != necir_pkg::IDX_MAX)
         frame_pos = frame_pos + IDX_W'(1);
      if (!p.last_item)
         return 1'b0;
      if (!leader_seen) begin
         r.status = necir_pkg::STATUS_BAD_LEADER;
      end else if (addr_b != ~addr_inv_b || cmd_b != ~cmd_inv_b) begin
         r.status = necir_pkg::STATUS_MISMATCH;
      end else begin
         r.frame_valid = 1'b1;
         r.status      = necir_pkg::STATUS_OK;
         r.address     = addr_b;
         r.command     = cmd_b;
      end
      frame_pos    = '0;
      leader_seen  = 1'b0;
      bits_in_byte = '0;
      byte_acc     = '0;
      addr_b       = '0;
      addr_inv_b   = '0;
      cmd_b        = '0;
      cmd_inv_b    = '0;
      return 1'b1;
   endfunction

   // predict on every accepted request beat
   always @(posedge clock) begin
      necir_pkg::rsp_type r;
      if (!reset && req_valid && !req_stall) begin
         if (decode_pair(req_data, r))
            pending_frames.push_back(req_fixed ? req_fixed_rsp : r);
      end
   end

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (want !== got) begin
         $display("%0t result %s mismatch: expected %h actual %h", $time, name, want, got);
         fail_count++;
      end
   endtask

   // compare every accepted result beat with the oldest prediction
   always @(posedge clock) begin
      necir_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_frames.size() == 0) begin
            $display("%0t unexpected result: expected none actual %h", $time, rsp_data);
            fail_count++;
         end else begin
            want = pending_frames.pop_front();
            check_field("frame_valid", 8'(want.frame_valid), 8'(rsp_data.frame_valid));
            check_field("status", 8'(want.status), 8'(rsp_data.status));
            check_field("address", want.address, rsp_data.address);
            check_field("command", want.command, rsp_data.command);
         end
      end
   end

   // result stall pattern, changing density at random intervals
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_left <= $urandom_range(50, 400);
         stall_pct  <= 30 * $urandom_range(0, 3);
      end else begin
         stall_left <= stall_left - 1;
      end
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // watchdog on cycles with no beat moving anywhere
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // present one request beat, then maybe close the burst with a gap
   task automatic send_beat(input necir_pkg::req_type d, input bit fixed = 1'b0,
                            input necir_pkg::rsp_type want = '0);
      req_valid     <= 1'b1;
      req_data      <= d;
      req_fixed     <= fixed;
      req_fixed_rsp <= want;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      beats_sent++;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   // wait out all results plus the tail of any pair still in work
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic write_divisor(input logic [DIV_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      tick_div = value;
   endtask

   // stimulus shaping at the current divisor
   function automatic logic [TICK_W-1:0] us_to_ticks(input int us);
      int d;
      int t;
      d = (tick_div == 0) ? 1 : int'(tick_div);
      t = (us < 0) ? 0 : (us * d + 9) / 10;
      if (t > 32767)
         t = 32767;
      return TICK_W'(t);
   endfunction

   function automatic int wobble(input int center, input int span);
      return center - span + int'($urandom_range(0, 2 * span));
   endfunction

   function automatic necir_pkg::req_type leader_pair(input bit last);
      necir_pkg::req_type p;
      p.low_ticks  = us_to_ticks(wobble(9000, 185));
      p.high_ticks = ($urandom_range(0, 15) == 0) ? '0 : us_to_ticks(wobble(4500, 185));
      p.last_item  = last;
      return p;
   endfunction

   function automatic necir_pkg::req_type bit_pair(input bit value, input bit last);
      necir_pkg::req_type p;
      p.low_ticks  = us_to_ticks(wobble(560, 85));
      p.high_ticks = ($urandom_range(0, 15) == 0) ? '0 :
                     us_to_ticks(wobble(value ? 1690 : 560, 85));
      p.last_item  = last;
      return p;
   endfunction

   function automatic necir_pkg::req_type junk_pair(input bit last);
      necir_pkg::req_type p;
      if ($urandom_range(0, 1) == 0) begin
         p.low_ticks  = TICK_W'($urandom_range(0, 32767));
         p.high_ticks = TICK_W'($urandom_range(0, 32767));
      end else begin
         p.low_ticks  = us_to_ticks($urandom_range(0, 2500));
         p.high_ticks = us_to_ticks($urandom_range(0, 2500));
      end
      p.last_item = last;
      return p;
   endfunction

   // one frame: mostly well formed, some noise and some broken frames
   task automatic run_frame();
      int          kind;
      int          sel;
      int          nbits;
      int          k;
      logic [7:0]  addr;
      logic [7:0]  cmd;
      logic [31:0] word;
      bit          v;
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
         addr = 8'($urandom);
         cmd  = 8'($urandom);
         word = {~cmd, cmd, ~addr, addr};
         if ($urandom_range(0, 4) == 0)
            word[$urandom_range(0, 31)] ^= 1'b1;
         sel = $urandom_range(0, 19);
         nbits = (sel < 14) ? 32 : (sel < 17) ? $urandom_range(0, 31) :
                 $urandom_range(33, 70);
         send_beat(leader_pair(nbits == 0));
         for (k = 0; k < nbits; k++) begin
            v = (k < 32) ? word[k] : 1'($urandom_range(0, 1));
            if ($urandom_range(0, 39) == 0)
               send_beat(junk_pair(k == nbits - 1));
            else
               send_beat(bit_pair(v, k == nbits - 1));
         end
      end else if (kind < 9) begin
         nbits = $urandom_range(1, 8);
         for (k = 0; k < nbits; k++)
            send_beat(junk_pair(k == nbits - 1));
      end else begin
         nbits = $urandom_range(0, 40);
         if ($urandom_range(0, 1) == 0)
            send_beat(junk_pair(nbits == 0));
         else
            send_beat(leader_pair(nbits == 0));
         for (k = 0; k < nbits; k++) begin
            if ($urandom_range(0, 2) == 0)
               send_beat(junk_pair(k == nbits - 1));
            else
               send_beat(bit_pair(1'($urandom_range(0, 1)), k == nbits - 1));
         end
      end
   endtask

   initial begin
      int phase_divs [8];
      int target;
      necir_pkg::req_type d;
      phase_divs = '{8, 1, 255, 0, 8, 8, 8, 8};
      phase_divs[4] = $urandom_range(2, 36);
      phase_divs[5] = $urandom_range(37, 254);
      phase_divs[6] = $urandom_range(2, 36);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed beats at the reset divisor
      foreach (DIR_ROWS[i]) begin
         d.low_ticks  = DIR_ROWS[i].mark;
         d.high_ticks = DIR_ROWS[i].space;
         d.last_item  = DIR_ROWS[i].last;
         send_beat(d, DIR_ROWS[i].fixed, DIR_ROWS[i].want);
      end

      // random frames, one divisor per phase
      for (int ph = 0; ph < 8; ph++) begin
         if (ph > 0) begin
            settle();
            write_divisor(DIV_W'(phase_divs[ph]));
         end
         target = beats_sent + PHASE_BEATS;
         while (beats_sent < target)
            run_frame();
      end

      settle();
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
